// File: src/bfps_pkg.sv
// Package for the byte-fair priority packet scheduler.
// Holds default sizes, request and status codes and the sequencer state type.
// No dependencies.
package bfps_pkg;

  localparam int NumStreamsDef    = 16;
  localparam int PktDepthDef      = 64;
  localparam int ByteCountBitsDef = 48;
  localparam logic [15:0] LeadLimitReset = 16'd1400;

  localparam logic ReqPush = 1'b0;
  localparam logic ReqPop  = 1'b1;

  typedef enum logic [2:0] {
    ST_PUSHED   = 3'd0,
    ST_POPPED   = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NO_SLOT  = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PSCAN,
    S_PFIN,
    S_SCAN1,
    S_SCAN2,
    S_SCAN3,
    S_POPFIN,
    S_OUT
  } state_t;

endpackage

// File: src/bfps_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bfps_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/byte_fair_priority_packet_scheduler_top.sv
// Top level of the byte-fair priority packet scheduler.
// Uses bfps_pkg and two bfps_ram instances (packet entries, stream slots).
//
// Channel  Dir  Handshake            Payload
// in_      in   in_valid/in_stall    req_type stream_id prio_level arrival_order
//                                    packet_bytes packet_handle
// out_     out  out_valid/out_stall  status handle stream bytes queue_empty count
// cfg_     in   cfg_we               cfg_wdata (lead_limit_bytes)
//
// A push searches the stream ids through the slot RAM, one slot a cycle; a pop
// makes two passes over the entry RAM and one over the slot RAM.
// A push to a full store or a pop from an empty one skips the scans and goes to the output state.
// Reset is synchronous; no clearing pass is needed.
// One transaction at a time; a finished result waits in the output register
// while the next input transaction is taken.
module byte_fair_priority_packet_scheduler_top #(
  parameter int NUM_STREAMS     = bfps_pkg::NumStreamsDef,
  parameter int PKT_DEPTH       = bfps_pkg::PktDepthDef,
  parameter int BYTE_COUNT_BITS = bfps_pkg::ByteCountBitsDef,
  localparam int CNT_W = $clog2(PKT_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_req_type,
  input  logic [31:0]      in_stream_id,
  input  logic [3:0]       in_prio_level,
  input  logic [31:0]      in_arrival_order,
  input  logic [15:0]      in_packet_bytes,
  input  logic [15:0]      in_packet_handle,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       out_status,
  output logic [15:0]      out_handle,
  output logic [31:0]      out_stream,
  output logic [15:0]      out_bytes,
  output logic             out_queue_empty,
  output logic [CNT_W-1:0] out_queued_count,
  input  logic             cfg_we,
  input  logic [15:0]      cfg_wdata
);

  localparam int EA_W  = $clog2(PKT_DEPTH);
  localparam int SA_W  = $clog2(NUM_STREAMS);
  localparam int SC_W  = $clog2(NUM_STREAMS + 1);
  localparam int MAXD  = (PKT_DEPTH > NUM_STREAMS) ? PKT_DEPTH : NUM_STREAMS;
  localparam int IX_W  = $clog2(MAXD + 1);
  localparam int BC    = BYTE_COUNT_BITS;
  localparam int EW    = 4 + 32 + 16 + 16 + SA_W;
  localparam int SW    = 32 + BC;
  localparam logic [BC-1:0] ByteMax = {BC{1'b1}};

  bfps_pkg::state_t state_r, state_nxt;

  logic [15:0]          lead_r;
  logic [BC-1:0]        leader_r, leader_nxt;
  logic [CNT_W-1:0]     held_r, held_nxt;
  logic [SC_W-1:0]      slot_cnt_r, slot_cnt_nxt;
  logic [PKT_DEPTH-1:0] valid_r, valid_nxt;

  // latched request
  logic [31:0] sid_r;
  logic [3:0]  prio_r;
  logic [31:0] ord_r;
  logic [15:0] pbytes_r, hdl_r;

  // scan control
  logic [IX_W-1:0] idx_r, idx_nxt;
  logic            done_r, done_nxt;
  logic            vd_r, vd_nxt;
  logic [IX_W-1:0] vidx_r, vidx_nxt;
  logic [IX_W-1:0] last_idx;

  // pop scan state
  logic [NUM_STREAMS-1:0] has_r, has_nxt;
  logic [3:0]             minp_r [NUM_STREAMS];
  logic [3:0]             minp_nxt [NUM_STREAMS];
  logic            bfound_r, bfound_nxt;
  logic [3:0]      bp_r, bp_nxt;
  logic [BC-1:0]   bbytes_r, bbytes_nxt;
  logic [SA_W-1:0] bslot_r, bslot_nxt;
  logic [31:0]     bsid_r, bsid_nxt;
  logic            efound_r, efound_nxt;
  logic [3:0]      ep_r, ep_nxt;
  logic [31:0]     eord_r, eord_nxt;
  logic [EA_W-1:0] eidx_r, eidx_nxt;
  logic [15:0]     eb_r, eb_nxt, eh_r, eh_nxt;

  // push slot search
  logic            found_r, found_nxt;
  logic [SA_W-1:0] fslot_r, fslot_nxt;

  // result waiting to be loaded
  bfps_pkg::status_t rst_st_r, rst_st_nxt;
  logic [15:0] res_h_r, res_h_nxt, res_b_r, res_b_nxt;
  logic [31:0] res_s_r, res_s_nxt;

  logic              ov_r;
  bfps_pkg::status_t ost_r;
  logic [15:0]       oh_r, ob_r;
  logic [31:0]       os_r;
  logic              oe_r;
  logic [CNT_W-1:0]  oc_r;
  logic              out_load;

  // memories
  logic            e_we;
  logic [EA_W-1:0] e_waddr;
  logic [EW-1:0]   e_wdata, e_rdata;
  logic            s_we;
  logic [SA_W-1:0] s_waddr;
  logic [SW-1:0]   s_wdata, s_rdata;

  logic [3:0]      rd_prio;
  logic [31:0]     rd_ord;
  logic [15:0]     rd_bytes, rd_hdl;
  logic [SA_W-1:0] rd_slot;
  logic [31:0]     rd_sid;
  logic [BC-1:0]   rd_sent;

  logic [EA_W-1:0] free_idx;
  logic [BC-1:0]   lead_ext, floor_b, sz;
  logic [BC:0]     sum_b;
  logic            in_acc;

  assign {rd_prio, rd_ord, rd_bytes, rd_hdl, rd_slot} = e_rdata;
  assign {rd_sid, rd_sent} = s_rdata;

  bfps_ram #(.W(EW), .D(PKT_DEPTH)) u_entry_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (idx_r[EA_W-1:0]),
    .rdata (e_rdata)
  );

  bfps_ram #(.W(SW), .D(NUM_STREAMS)) u_slot_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (idx_r[SA_W-1:0]),
    .rdata (s_rdata)
  );

  assign in_stall = (state_r != bfps_pkg::S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    free_idx = '0;
    for (int i = PKT_DEPTH - 1; i >= 0; i--) begin
      if (!valid_r[i]) free_idx = EA_W'(i);
    end
  end

  assign lead_ext = BC'(lead_r);
  assign floor_b  = (leader_r > lead_ext) ? (leader_r - lead_ext) : '0;
  assign sum_b    = {1'b0, bbytes_r} + (BC + 1)'(eb_r);
  always_comb begin
    sz = sum_b[BC] ? ByteMax : sum_b[BC-1:0];
    if (sz < floor_b) sz = floor_b;
  end

  always_comb begin
    if (state_r == bfps_pkg::S_SCAN1 || state_r == bfps_pkg::S_SCAN3) begin
      last_idx = IX_W'(PKT_DEPTH - 1);
    end else begin
      last_idx = IX_W'(slot_cnt_r) - IX_W'(1);
    end
  end

  assign out_load = (state_r == bfps_pkg::S_OUT) && !(ov_r && out_stall);

  always_comb begin
    state_nxt    = state_r;
    leader_nxt   = leader_r;
    held_nxt     = held_r;
    slot_cnt_nxt = slot_cnt_r;
    valid_nxt    = valid_r;
    idx_nxt      = idx_r;
    done_nxt     = done_r;
    vd_nxt       = 1'b0;
    vidx_nxt     = vidx_r;
    has_nxt      = has_r;
    minp_nxt     = minp_r;
    bfound_nxt   = bfound_r;
    bp_nxt       = bp_r;
    bbytes_nxt   = bbytes_r;
    bslot_nxt    = bslot_r;
    bsid_nxt     = bsid_r;
    efound_nxt   = efound_r;
    ep_nxt       = ep_r;
    eord_nxt     = eord_r;
    eidx_nxt     = eidx_r;
    eb_nxt       = eb_r;
    eh_nxt       = eh_r;
    found_nxt    = found_r;
    fslot_nxt    = fslot_r;
    rst_st_nxt   = rst_st_r;
    res_h_nxt    = res_h_r;
    res_b_nxt    = res_b_r;
    res_s_nxt    = res_s_r;
    e_we         = 1'b0;
    e_waddr      = free_idx;
    e_wdata      = {prio_r, ord_r, pbytes_r, hdl_r, slot_cnt_r[SA_W-1:0]};
    s_we         = 1'b0;
    s_waddr      = slot_cnt_r[SA_W-1:0];
    s_wdata      = {sid_r, {BC{1'b0}}};

    // issue one read per cycle during a scan
    if (state_r == bfps_pkg::S_PSCAN || state_r == bfps_pkg::S_SCAN1 ||
        state_r == bfps_pkg::S_SCAN2 || state_r == bfps_pkg::S_SCAN3) begin
      if (!done_r) begin
        vd_nxt   = 1'b1;
        vidx_nxt = idx_r;
        if (idx_r == last_idx) done_nxt = 1'b1;
        else idx_nxt = idx_r + IX_W'(1);
      end
    end

    unique case (state_r)
      bfps_pkg::S_IDLE: begin
        idx_nxt    = '0;
        done_nxt   = 1'b0;
        res_h_nxt  = '0;
        res_b_nxt  = '0;
        res_s_nxt  = '0;
        found_nxt  = 1'b0;
        bfound_nxt = 1'b0;
        efound_nxt = 1'b0;
        has_nxt    = '0;
        if (in_acc) begin
          if (in_req_type == bfps_pkg::ReqPush) begin
            if (held_r >= CNT_W'(PKT_DEPTH)) begin
              rst_st_nxt = bfps_pkg::ST_FULL;
              state_nxt  = bfps_pkg::S_OUT;
            end else if (slot_cnt_r == '0) begin
              state_nxt = bfps_pkg::S_PFIN;
            end else begin
              state_nxt = bfps_pkg::S_PSCAN;
            end
          end else if (held_r == '0) begin
            rst_st_nxt = bfps_pkg::ST_EMPTY;
            state_nxt  = bfps_pkg::S_OUT;
          end else begin
            state_nxt = bfps_pkg::S_SCAN1;
          end
        end
      end
      bfps_pkg::S_PSCAN: begin
        if (vd_r && !found_r && rd_sid == sid_r) begin
          found_nxt = 1'b1;
          fslot_nxt = vidx_r[SA_W-1:0];
        end
        if (done_r && !vd_r) state_nxt = bfps_pkg::S_PFIN;
      end
      bfps_pkg::S_PFIN: begin
        state_nxt = bfps_pkg::S_OUT;
        if (found_r) begin
          e_wdata = {prio_r, ord_r, pbytes_r, hdl_r, fslot_r};
        end
        if (!found_r && slot_cnt_r == SC_W'(NUM_STREAMS)) begin
          rst_st_nxt = bfps_pkg::ST_NO_SLOT;
        end else begin
          if (!found_r) begin
            // open the lowest free slot with a zero byte count
            s_we         = 1'b1;
            slot_cnt_nxt = slot_cnt_r + SC_W'(1);
          end
          e_we                = 1'b1;
          valid_nxt[free_idx] = 1'b1;
          held_nxt            = held_r + CNT_W'(1);
          rst_st_nxt          = bfps_pkg::ST_PUSHED;
        end
      end
      bfps_pkg::S_SCAN1: begin
        if (vd_r && valid_r[vidx_r[EA_W-1:0]]) begin
          if (!has_r[rd_slot] || rd_prio < minp_r[rd_slot]) begin
            minp_nxt[rd_slot] = rd_prio;
          end
          has_nxt[rd_slot] = 1'b1;
        end
        if (done_r && !vd_r) begin
          state_nxt = bfps_pkg::S_SCAN2;
          idx_nxt   = '0;
          done_nxt  = 1'b0;
        end
      end
      bfps_pkg::S_SCAN2: begin
        if (vd_r && has_r[vidx_r[SA_W-1:0]]) begin
          if (!bfound_r || minp_r[vidx_r[SA_W-1:0]] < bp_r ||
              (minp_r[vidx_r[SA_W-1:0]] == bp_r && rd_sent < bbytes_r)) begin
            bfound_nxt = 1'b1;
            bp_nxt     = minp_r[vidx_r[SA_W-1:0]];
            bbytes_nxt = rd_sent;
            bslot_nxt  = vidx_r[SA_W-1:0];
            bsid_nxt   = rd_sid;
          end
        end
        if (done_r && !vd_r) begin
          state_nxt = bfps_pkg::S_SCAN3;
          idx_nxt   = '0;
          done_nxt  = 1'b0;
        end
      end
      bfps_pkg::S_SCAN3: begin
        if (vd_r && valid_r[vidx_r[EA_W-1:0]] && rd_slot == bslot_r) begin
          if (!efound_r || rd_prio < ep_r || (rd_prio == ep_r && rd_ord < eord_r)) begin
            efound_nxt = 1'b1;
            ep_nxt     = rd_prio;
            eord_nxt   = rd_ord;
            eidx_nxt   = vidx_r[EA_W-1:0];
            eb_nxt     = rd_bytes;
            eh_nxt     = rd_hdl;
          end
        end
        if (done_r && !vd_r) state_nxt = bfps_pkg::S_POPFIN;
      end
      bfps_pkg::S_POPFIN: begin
        // charge the served stream, floored to the leader minus the lead limit
        s_we              = 1'b1;
        s_waddr           = bslot_r;
        s_wdata           = {bsid_r, sz};
        if (sz > leader_r) leader_nxt = sz;
        valid_nxt[eidx_r] = 1'b0;
        held_nxt          = held_r - CNT_W'(1);
        rst_st_nxt        = bfps_pkg::ST_POPPED;
        res_h_nxt         = eh_r;
        res_b_nxt         = eb_r;
        res_s_nxt         = bsid_r;
        state_nxt         = bfps_pkg::S_OUT;
      end
      bfps_pkg::S_OUT: begin
        if (out_load) state_nxt = bfps_pkg::S_IDLE;
      end
      default: state_nxt = bfps_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= bfps_pkg::S_IDLE;
      lead_r     <= bfps_pkg::LeadLimitReset;
      leader_r   <= BC'(bfps_pkg::LeadLimitReset);
      held_r     <= '0;
      slot_cnt_r <= '0;
      valid_r    <= '0;
      vd_r       <= 1'b0;
      done_r     <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      if (cfg_we) lead_r <= cfg_wdata;
      leader_r   <= leader_nxt;
      held_r     <= held_nxt;
      slot_cnt_r <= slot_cnt_nxt;
      valid_r    <= valid_nxt;
      vd_r       <= vd_nxt;
      done_r     <= done_nxt;
      if (out_load) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      sid_r    <= in_stream_id;
      prio_r   <= in_prio_level;
      ord_r    <= in_arrival_order;
      pbytes_r <= in_packet_bytes;
      hdl_r    <= in_packet_handle;
    end
    idx_r    <= idx_nxt;
    vidx_r   <= vidx_nxt;
    has_r    <= has_nxt;
    minp_r   <= minp_nxt;
    bfound_r <= bfound_nxt;
    bp_r     <= bp_nxt;
    bbytes_r <= bbytes_nxt;
    bslot_r  <= bslot_nxt;
    bsid_r   <= bsid_nxt;
    efound_r <= efound_nxt;
    ep_r     <= ep_nxt;
    eord_r   <= eord_nxt;
    eidx_r   <= eidx_nxt;
    eb_r     <= eb_nxt;
    eh_r     <= eh_nxt;
    found_r  <= found_nxt;
    fslot_r  <= fslot_nxt;
    rst_st_r <= rst_st_nxt;
    res_h_r  <= res_h_nxt;
    res_b_r  <= res_b_nxt;
    res_s_r  <= res_s_nxt;
    if (out_load) begin
      ost_r <= rst_st_r;
      oh_r  <= res_h_r;
      ob_r  <= res_b_r;
      os_r  <= res_s_r;
      oe_r  <= (held_r == '0);
      oc_r  <= held_r;
    end
  end

  assign out_valid        = ov_r;
  assign out_status       = ost_r;
  assign out_handle       = oh_r;
  assign out_stream       = os_r;
  assign out_bytes        = ob_r;
  assign out_queue_empty  = oe_r;
  assign out_queued_count = oc_r;

  a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'($countones(valid_r)) == held_r)
    else $error("held count differs from number of valid entries");

  a_slot_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    slot_cnt_r <= SC_W'(NUM_STREAMS))
    else $error("stream slot count beyond slot store");

  a_leader_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> leader_r >= $past(leader_r))
    else $error("leader byte count decreased");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bfps_pkg::S_POPFIN |-> efound_r && bfound_r)
    else $error("pop finished without a selected entry");

endmodule
